### hw/rtl/cpb_pkg.sv
// Package for the cascaded PI balance controller.
// Holds the arithmetic unit request/response types, fixed-point constants
// and saturation helpers. No dependencies.
package cpb_pkg;

  localparam int DRIVE_LIMIT_DEF = 300;
  localparam int DIV_W = 10;

  // Metres per encoder count in Q0.40, and radians per millidegree in Q0.32.
  localparam logic signed [31:0] MPC_Q40 = 32'sd141711464;
  localparam logic signed [31:0] RAD_PER_MDEG_Q32 = 32'sd74961;
  // Metres per count times milliseconds per second, used for wheel speed.
  localparam logic signed [63:0] WHEEL_K = 64'sd141711464000;
  localparam logic signed [63:0] DESIRED_MIN = -64'sd393216;
  localparam logic signed [63:0] Q32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q32_MIN = -64'sd2147483648;
  localparam logic [DIV_W-1:0] MS_PER_S = DIV_W'(1000);

  typedef struct packed {
    logic               start;
    logic               is_div;
    logic signed [63:0] a;
    logic signed [31:0] b;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] result;
  } arith_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > Q32_MAX) return Q32_MAX[31:0];
    if (v < Q32_MIN) return Q32_MIN[31:0];
    return v[31:0];
  endfunction

  // Integer part toward zero of a Q16.16 value, clamped to the drive limit.
  function automatic logic signed [15:0] drive_of(input logic signed [63:0] pwm,
                                                  input logic signed [15:0] lim);
    logic signed [63:0] ip;
    logic signed [63:0] lim_w;
    ip = (pwm >= 0) ? (pwm >>> 16) : -((-pwm) >>> 16);
    lim_w = 64'(lim);
    if (ip > lim_w) return lim;
    if (ip < -lim_w) return -lim;
    return ip[15:0];
  endfunction

endpackage

### hw/rtl/cpb_arith.sv
// Shared bit-serial arithmetic unit: signed shift-add multiply (one
// multiplier bit per cycle) and restoring divide by a small positive divisor.
// Depends on cpb_pkg.
module cpb_arith (
  input  logic                   clk,
  input  logic                   rst,
  input  cpb_pkg::arith_req_t    req,
  output cpb_pkg::arith_rsp_t    rsp
);

  logic                      busy;
  logic                      is_div;
  logic                      neg;
  logic [6:0]                cnt;
  logic [63:0]               ma;
  logic [63:0]               acc;
  logic [31:0]               mb;
  logic [cpb_pkg::DIV_W-1:0] rem;

  logic [63:0]               a_mag;
  logic [31:0]               b_mag;
  logic [cpb_pkg::DIV_W:0]   rem_sh;
  logic [cpb_pkg::DIV_W:0]   rem_sub;
  logic                      fits;

  always_comb begin
    a_mag   = req.a[63] ? 64'(-req.a) : 64'(req.a);
    b_mag   = req.b[31] ? 32'(-req.b) : 32'(req.b);
    rem_sh  = {rem, ma[63]};
    fits    = rem_sh >= {1'b0, mb[cpb_pkg::DIV_W-1:0]};
    rem_sub = rem_sh - {1'b0, mb[cpb_pkg::DIV_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (!busy && req.start) begin
        busy   <= 1'b1;
        is_div <= req.is_div;
        cnt    <= req.is_div ? 7'd64 : 7'd32;
        ma     <= a_mag;
        mb     <= req.is_div ? req.b : b_mag;
        neg    <= req.is_div ? req.a[63] : (req.a[63] ^ req.b[31]);
        acc    <= '0;
        rem    <= '0;
      end else if (busy) begin
        if (cnt == 7'd0) begin
          busy       <= 1'b0;
          rsp.done   <= 1'b1;
          rsp.result <= neg ? -$signed(acc) : $signed(acc);
        end else begin
          cnt <= cnt - 7'd1;
          ma  <= ma << 1;
          if (is_div) begin
            rem <= fits ? rem_sub[cpb_pkg::DIV_W-1:0] : rem_sh[cpb_pkg::DIV_W-1:0];
            acc <= {acc[62:0], fits};
          end else begin
            if (mb[0]) acc <= acc + ma;
            mb <= mb >> 1;
          end
        end
      end
    end
  end

endmodule

### hw/rtl/cascaded_pi_balance_controller_unit.sv
// Top level of the cascaded PI balance controller.
// Depends on cpb_pkg and cpb_arith.
//
// One input transfer is one control period: tilt, wheel encoder deltas and
// totals, and the elapsed time. Each input transfer yields exactly one
// output transfer carrying both drive values, the phase after the period
// and the arming beep. Both channels use valid/ready handshakes; the APB
// port writes and reads the eight gain and threshold registers and should
// only be written while the block is idle.
// Outside the controlled phase the result passes through S_DONE into the
// output register once that register is free. In the controlled phase the
// period runs through one shared bit-serial unit: 14 multiplies and 5
// divides, issued one at a time by the step sequencer.
// A new input is taken once the previous period is finished, even while
// its result still waits in the output register; if the receiver stalls,
// the finished next result holds until the output register is free.
// Synchronous reset restores the register defaults, the waiting phase, a
// zero arm counter and cleared integrators.
module cascaded_pi_balance_controller_unit #(
  parameter int DRIVE_LIMIT = cpb_pkg::DRIVE_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [18:0] tilt_mdeg,
  input  logic signed [15:0] left_delta_counts,
  input  logic signed [15:0] right_delta_counts,
  input  logic signed [31:0] left_total_counts,
  input  logic signed [31:0] right_total_counts,
  input  logic [9:0]         elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [9:0]  left_drive,
  output logic signed [9:0]  right_drive,
  output logic [1:0]         phase,
  output logic               beep
);

  localparam logic signed [15:0] LIM = 16'(DRIVE_LIMIT);

  // Phase codes as seen on the phase output.
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_CTRL = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] R_OKP = 3'd0;
  localparam logic [2:0] R_OKI = 3'd1;
  localparam logic [2:0] R_IKP = 3'd2;
  localparam logic [2:0] R_IKI = 3'd3;
  localparam logic [2:0] R_BAND = 3'd4;
  localparam logic [2:0] R_TICKS = 3'd5;
  localparam logic [2:0] R_LIMIT = 3'd6;
  localparam logic [2:0] R_DGAIN = 3'd7;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  // Each step issues one operation to the shared unit and stores its result.
  typedef enum logic [4:0] {
    ST_DIST, ST_SETP, ST_ANGLE, ST_OKP, ST_OKI,
    ST_LVM, ST_LVD, ST_RVM, ST_RVD,
    ST_LJP, ST_LJI, ST_RJP, ST_RJI,
    ST_AIM, ST_AID, ST_LIM, ST_LID, ST_RIM, ST_RID
  } step_t;

  // Configuration registers.
  logic signed [31:0] outer_prop_gain, outer_integral_gain;
  logic signed [31:0] inner_prop_gain, inner_integral_gain;
  logic [16:0]        arm_band_mdeg;
  logic [7:0]         arm_ticks;
  logic [17:0]        tilt_limit_mdeg;
  logic [16:0]        distance_to_angle_gain;

  // Controller state.
  logic [1:0]         phase_reg;
  logic [7:0]         arm_counter;
  logic signed [31:0] angle_integral, left_vel_integral, right_vel_integral;

  state_t             state;
  step_t              step;
  logic               issued;

  // Captured period and working values.
  logic signed [18:0] tilt_r;
  logic signed [15:0] dl_r, dr_r;
  logic signed [32:0] tsum_r;
  logic [9:0]         ms_r;
  logic [19:0]        mag_r;
  logic               beep_r;
  logic signed [63:0] dist_q, tmp;
  logic signed [31:0] setpoint, aerr, vel, lerr, rerr;
  logic signed [15:0] ldrive_r, rdrive_r;

  cpb_pkg::arith_req_t req;
  cpb_pkg::arith_rsp_t rsp;

  logic [19:0]        mag;
  logic               in_band, outside;
  logic [7:0]         cnt_a, cnt_next;
  logic [1:0]         phase_next;
  logic               beep_next;
  logic signed [63:0] diff;
  logic               wr_en;

  cpb_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    unique case (paddr[4:2])
      R_OKP:   prdata = outer_prop_gain;
      R_OKI:   prdata = outer_integral_gain;
      R_IKP:   prdata = inner_prop_gain;
      R_IKI:   prdata = inner_integral_gain;
      R_BAND:  prdata = {15'd0, arm_band_mdeg};
      R_TICKS: prdata = {24'd0, arm_ticks};
      R_LIMIT: prdata = {14'd0, tilt_limit_mdeg};
      R_DGAIN: prdata = {15'd0, distance_to_angle_gain};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_prop_gain        <= -32'sd393216;
      outer_integral_gain    <= -32'sd2359296;
      inner_prop_gain        <= 32'sd39321600;
      inner_integral_gain    <= 32'sd393216000;
      arm_band_mdeg          <= 17'd3000;
      arm_ticks              <= 8'd30;
      tilt_limit_mdeg        <= 18'd44690;
      distance_to_angle_gain <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        R_OKP:   outer_prop_gain        <= pwdata;
        R_OKI:   outer_integral_gain    <= pwdata;
        R_IKP:   inner_prop_gain        <= pwdata;
        R_IKI:   inner_integral_gain    <= pwdata;
        R_BAND:  arm_band_mdeg          <= pwdata[16:0];
        R_TICKS: arm_ticks              <= pwdata[7:0];
        R_LIMIT: tilt_limit_mdeg        <= pwdata[17:0];
        R_DGAIN: distance_to_angle_gain <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Phase machine, evaluated on the incoming period. The band edge itself
  // counts as neither inside nor outside.
  always_comb begin
    mag        = tilt_mdeg[18] ? 20'(-21'(tilt_mdeg)) : 20'(tilt_mdeg);
    in_band    = mag < {3'd0, arm_band_mdeg};
    outside    = mag > {3'd0, arm_band_mdeg};
    cnt_a      = outside ? 8'd0 : arm_counter;
    cnt_next   = cnt_a;
    phase_next = phase_reg;
    beep_next  = 1'b0;
    if (phase_reg == PH_WAIT && in_band) begin
      cnt_next = (cnt_a == 8'hFF) ? cnt_a : cnt_a + 8'd1;
      if (cnt_next > arm_ticks) begin
        phase_next = PH_ARMED;
        beep_next  = 1'b1;
      end
    end else if (phase_reg == PH_ARMED && outside) begin
      phase_next = PH_CTRL;
    end else if (phase_reg > PH_CTRL) begin
      phase_next = PH_WAIT;
    end
  end

  // Setpoint from distance: drive back toward -6 m once past it, else to 0.
  assign diff = ((dist_q < cpb_pkg::DESIRED_MIN) ? cpb_pkg::DESIRED_MIN : 64'sd0) - dist_q;

  // Operand selection for the current step.
  always_comb begin
    req.start  = (state == S_RUN) && !issued;
    req.is_div = 1'b0;
    req.a      = '0;
    req.b      = '0;
    unique case (step)
      ST_DIST:  begin req.a = 64'(tsum_r);          req.b = cpb_pkg::MPC_Q40; end
      ST_SETP:  begin req.a = diff;                 req.b = {15'd0, distance_to_angle_gain}; end
      ST_ANGLE: begin req.a = 64'(tilt_r);          req.b = cpb_pkg::RAD_PER_MDEG_Q32; end
      ST_OKP:   begin req.a = 64'(aerr);            req.b = outer_prop_gain; end
      ST_OKI:   begin req.a = 64'(angle_integral);  req.b = outer_integral_gain; end
      ST_LVM:   begin req.a = cpb_pkg::WHEEL_K;     req.b = 32'(dl_r); end
      ST_RVM:   begin req.a = cpb_pkg::WHEEL_K;     req.b = 32'(dr_r); end
      ST_LVD, ST_RVD: begin
        req.is_div = 1'b1; req.a = tmp; req.b = {22'd0, ms_r};
      end
      ST_LJP:   begin req.a = 64'(lerr);              req.b = inner_prop_gain; end
      ST_LJI:   begin req.a = 64'(left_vel_integral); req.b = inner_integral_gain; end
      ST_RJP:   begin req.a = 64'(rerr);               req.b = inner_prop_gain; end
      ST_RJI:   begin req.a = 64'(right_vel_integral); req.b = inner_integral_gain; end
      ST_AIM:   begin req.a = 64'(aerr);            req.b = {22'd0, ms_r}; end
      ST_LIM:   begin req.a = 64'(lerr);            req.b = {22'd0, ms_r}; end
      ST_RIM:   begin req.a = 64'(rerr);            req.b = {22'd0, ms_r}; end
      ST_AID, ST_LID, ST_RID: begin
        req.is_div = 1'b1; req.a = tmp; req.b = {22'd0, cpb_pkg::MS_PER_S};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      step               <= ST_DIST;
      issued             <= 1'b0;
      phase_reg          <= PH_WAIT;
      arm_counter        <= '0;
      angle_integral     <= '0;
      left_vel_integral  <= '0;
      right_vel_integral <= '0;
      out_valid          <= 1'b0;
    end else begin
      // The output register reloads in S_DONE; elsewhere a taken result clears it.
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tilt_r      <= tilt_mdeg;
            dl_r        <= left_delta_counts;
            dr_r        <= right_delta_counts;
            tsum_r      <= 33'(left_total_counts) + 33'(right_total_counts);
            ms_r        <= (elapsed_ms == 10'd0) ? 10'd1 : elapsed_ms;
            mag_r       <= mag;
            phase_reg   <= phase_next;
            arm_counter <= cnt_next;
            beep_r      <= beep_next;
            ldrive_r    <= '0;
            rdrive_r    <= '0;
            step        <= ST_DIST;
            issued      <= 1'b0;
            state       <= (phase_next == PH_CTRL) ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          if (!issued) begin
            issued <= 1'b1;
          end else if (rsp.done) begin
            issued <= 1'b0;
            case (step)
              ST_DIST:  begin dist_q <= rsp.result >>> 25; step <= ST_SETP; end
              ST_SETP:  begin
                setpoint <= cpb_pkg::sat32(rsp.result >>> 16); step <= ST_ANGLE;
              end
              ST_ANGLE: begin
                aerr <= cpb_pkg::sat32(64'(setpoint) - (rsp.result >>> 16));
                step <= ST_OKP;
              end
              ST_OKP:   begin tmp <= rsp.result >>> 16; step <= ST_OKI; end
              ST_OKI:   begin
                vel <= cpb_pkg::sat32(tmp + (rsp.result >>> 16)); step <= ST_LVM;
              end
              ST_LVM:   begin tmp <= rsp.result; step <= ST_LVD; end
              ST_LVD:   begin
                lerr <= cpb_pkg::sat32(64'(vel) - (rsp.result >>> 24)); step <= ST_RVM;
              end
              ST_RVM:   begin tmp <= rsp.result; step <= ST_RVD; end
              ST_RVD:   begin
                rerr <= cpb_pkg::sat32(64'(vel) - (rsp.result >>> 24)); step <= ST_LJP;
              end
              ST_LJP:   begin tmp <= rsp.result >>> 16; step <= ST_LJI; end
              ST_LJI:   begin
                ldrive_r <= cpb_pkg::drive_of(tmp + (rsp.result >>> 16), LIM);
                step     <= ST_RJP;
              end
              ST_RJP:   begin tmp <= rsp.result >>> 16; step <= ST_RJI; end
              ST_RJI:   begin
                rdrive_r <= cpb_pkg::drive_of(tmp + (rsp.result >>> 16), LIM);
                step     <= ST_AIM;
              end
              ST_AIM:   begin tmp <= rsp.result; step <= ST_AID; end
              ST_AID:   begin
                angle_integral <= cpb_pkg::sat32(64'(angle_integral) + rsp.result);
                step           <= ST_LIM;
              end
              ST_LIM:   begin tmp <= rsp.result; step <= ST_LID; end
              ST_LID:   begin
                left_vel_integral <= cpb_pkg::sat32(64'(left_vel_integral) + rsp.result);
                step              <= ST_RIM;
              end
              ST_RIM:   begin tmp <= rsp.result; step <= ST_RID; end
              ST_RID:   begin
                // A tilt past the limit stops control and clears the loops.
                if (mag_r > {2'd0, tilt_limit_mdeg}) begin
                  phase_reg          <= PH_WAIT;
                  ldrive_r           <= '0;
                  rdrive_r           <= '0;
                  angle_integral     <= '0;
                  left_vel_integral  <= '0;
                  right_vel_integral <= '0;
                end else begin
                  right_vel_integral <= cpb_pkg::sat32(64'(right_vel_integral) + rsp.result);
                end
                state <= S_DONE;
              end
              default: ;
            endcase
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            left_drive  <= ldrive_r[9:0];
            right_drive <= rdrive_r[9:0];
            phase       <= phase_reg;
            beep        <= beep_r;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_beep_armed: assert property (@(posedge clk) disable iff (rst)
    out_valid && beep |-> phase == PH_ARMED)
    else $error("beep raised outside the arming transfer");
  a_drive_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase != PH_CTRL |-> left_drive == 10'd0 && right_drive == 10'd0)
    else $error("nonzero drive outside the controlled phase");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second input taken before the period finished");
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_RUN && issued)
    else $error("arithmetic result arrived with no operation pending");
`endif

endmodule

### tb/tb_cascaded_pi_balance_controller_unit.sv
// Self-checking testbench for cascaded_pi_balance_controller_unit.
// Depends on cpb_pkg and the unit RTL; holds its own predictor of the
// phase machine and the PI cascade, which is checked against every result.
module tb_cascaded_pi_balance_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam longint Q16_ONE = 65536;
  localparam int DRIVE_LIM = 300;

  // Phase codes as they appear on the phase output.
  typedef enum logic [1:0] {PH_WAIT = 2'd0, PH_ARMED = 2'd1, PH_CTRL = 2'd2} phase_e;

  // Register indexes; the byte address of a register is four times its index.
  typedef enum int {
    REG_OUTER_KP = 0, REG_OUTER_KI = 1, REG_INNER_KP = 2, REG_INNER_KI = 3,
    REG_BAND = 4, REG_TICKS = 5, REG_LIMIT = 6, REG_D2A = 7
  } reg_e;

  typedef struct {
    logic signed [18:0] tilt;
    logic signed [15:0] dl;
    logic signed [15:0] dr;
    logic signed [31:0] tl;
    logic signed [31:0] tr;
    logic [9:0]         ms;
  } period_t;

  typedef struct {
    logic [9:0] ld;
    logic [9:0] rd;
    logic [1:0] ph;
    logic       bp;
  } drive_t;

  // Scoreboard: predicts the outcome of each accepted control period and
  // compares the outputs, in order, against those predictions.
  class balance_scoreboard;
    longint okp, oki, ikp, iki, band, ticks, limit, d2a;
    phase_e ph;
    int arm_cnt;
    longint ang_int, l_int, r_int;
    drive_t pending_q[$];
    int errors, periods, results, ctrl_periods, arms;

    function void restore_defaults();
      okp = -393216; oki = -2359296; ikp = 39321600; iki = 393216000;
      band = 3000; ticks = 30; limit = 44690; d2a = 32768;
      ph = PH_WAIT; arm_cnt = 0; ang_int = 0; l_int = 0; r_int = 0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] v);
      case (idx)
        REG_OUTER_KP: okp = longint'(signed'(v));
        REG_OUTER_KI: oki = longint'(signed'(v));
        REG_INNER_KP: ikp = longint'(signed'(v));
        REG_INNER_KI: iki = longint'(signed'(v));
        REG_BAND:     band = v[16:0];
        REG_TICKS:    ticks = v[7:0];
        REG_LIMIT:    limit = v[17:0];
        REG_D2A:      d2a = v[16:0];
        default: ;
      endcase
    endfunction

    function longint clamp_q16(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint speed_q16(longint delta, longint ms);
      longint num;
      num = delta * longint'(cpb_pkg::MPC_Q40) * 1000;
      return (num / ms) >>> 24;
    endfunction

    function longint wheel_drive(longint err, longint acc);
      longint pwm, ip;
      pwm = ((ikp * err) >>> 16) + ((iki * acc) >>> 16);
      ip = (pwm >= 0) ? (pwm >>> 16) : -((-pwm) >>> 16);
      if (ip > DRIVE_LIM) ip = DRIVE_LIM;
      if (ip < -DRIVE_LIM) ip = -DRIVE_LIM;
      return ip;
    endfunction

    function void note_period(period_t p);
      longint tilt, mag, ms, dist_q, desired, setp, angle, aerr, vel, lerr, rerr;
      longint ldr, rdr;
      bit in_band, outside;
      drive_t r;
      tilt = longint'(p.tilt);
      mag = tilt < 0 ? -tilt : tilt;
      ms = (p.ms == 0) ? 1 : longint'(p.ms);
      in_band = mag < band;
      outside = mag > band;
      ldr = 0; rdr = 0; r.bp = 1'b0;
      periods++;
      if (outside) arm_cnt = 0;
      if (ph == PH_WAIT && in_band) begin
        if (arm_cnt < 255) arm_cnt++;
        if (arm_cnt > ticks) begin
          ph = PH_ARMED;
          r.bp = 1'b1;
          arms++;
        end
      end else if (ph == PH_ARMED && outside) begin
        ph = PH_CTRL;
      end
      if (ph == PH_CTRL) begin
        ctrl_periods++;
        dist_q = ((longint'(p.tl) + longint'(p.tr)) * longint'(cpb_pkg::MPC_Q40)) >>> 25;
        desired = (dist_q < -6 * Q16_ONE) ? -6 * Q16_ONE : 0;
        setp = clamp_q16(((desired - dist_q) * d2a) >>> 16);
        angle = (tilt * longint'(cpb_pkg::RAD_PER_MDEG_Q32)) >>> 16;
        aerr = clamp_q16(setp - angle);
        vel = clamp_q16(((okp * aerr) >>> 16) + ((oki * ang_int) >>> 16));
        lerr = clamp_q16(vel - speed_q16(longint'(p.dl), ms));
        rerr = clamp_q16(vel - speed_q16(longint'(p.dr), ms));
        ldr = wheel_drive(lerr, l_int);
        rdr = wheel_drive(rerr, r_int);
        ang_int = clamp_q16(ang_int + aerr * ms / 1000);
        l_int = clamp_q16(l_int + lerr * ms / 1000);
        r_int = clamp_q16(r_int + rerr * ms / 1000);
        // A tilt past the limit ends control and clears every integrator.
        if (mag > limit) begin
          ph = PH_WAIT;
          ldr = 0; rdr = 0;
          ang_int = 0; l_int = 0; r_int = 0;
        end
      end
      r.ld = ldr[9:0];
      r.rd = rdr[9:0];
      r.ph = ph;
      pending_q.push_back(r);
    endfunction

    function void check_result(drive_t got);
      drive_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: result with no period outstanding: ld=%0d rd=%0d ph=%0d bp=%0d",
                 $realtime, got.ld, got.rd, got.ph, got.bp);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      results++;
      if (got.ld !== exp_r.ld) begin
        $display("%0t: left_drive expected %0d actual %0d", $realtime,
                 $signed(exp_r.ld), $signed(got.ld));
        errors++;
      end
      if (got.rd !== exp_r.rd) begin
        $display("%0t: right_drive expected %0d actual %0d", $realtime,
                 $signed(exp_r.rd), $signed(got.rd));
        errors++;
      end
      if (got.ph !== exp_r.ph) begin
        $display("%0t: phase expected %0d actual %0d", $realtime, exp_r.ph, got.ph);
        errors++;
      end
      if (got.bp !== exp_r.bp) begin
        $display("%0t: beep expected %0d actual %0d", $realtime, exp_r.bp, got.bp);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [18:0] tilt_mdeg = '0;
  logic signed [15:0] left_delta_counts = '0, right_delta_counts = '0;
  logic signed [31:0] left_total_counts = '0, right_total_counts = '0;
  logic [9:0] elapsed_ms = 10'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [9:0] left_drive, right_drive;
  logic [1:0] phase;
  logic beep;

  balance_scoreboard sb;
  bit no_idle;
  longint cycles;
  int sent;

  always #10 clk = ~clk;

  cascaded_pi_balance_controller_unit i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .tilt_mdeg(tilt_mdeg), .left_delta_counts(left_delta_counts),
    .right_delta_counts(right_delta_counts), .left_total_counts(left_total_counts),
    .right_total_counts(right_total_counts), .elapsed_ms(elapsed_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_drive(left_drive), .right_drive(right_drive), .phase(phase), .beep(beep)
  );

  // Mostly back-to-back or short gaps, with the odd long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Both transfer sides are observed at the rising edge; the block's
  // registered outputs still hold their pre-edge values here.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      sb.note_period('{tilt_mdeg, left_delta_counts, right_delta_counts,
                       left_total_counts, right_total_counts, elapsed_ms});
    end
    if (!rst && out_valid && out_ready) begin
      sb.check_result('{left_drive, right_drive, phase, beep});
    end
  end

  // Receiver back-pressure, applied at the falling edge.
  int stall_left = 0;
  always @(negedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      stall_left <= gap_cycles();
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_cascaded_pi_balance_controller_unit: FAIL");
      $finish;
    end
  end

  // Called and returns at a falling edge.
  task automatic write_reg(reg_e idx, logic [31:0] v);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 5'(idx * 4); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Let every outstanding result drain so the registers can be rewritten.
  task automatic wait_idle();
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] okp, logic [31:0] oki, logic [31:0] ikp,
                           logic [31:0] iki, logic [31:0] band, logic [31:0] ticks,
                           logic [31:0] lim, logic [31:0] d2a);
    wait_idle();
    write_reg(REG_OUTER_KP, okp);
    write_reg(REG_OUTER_KI, oki);
    write_reg(REG_INNER_KP, ikp);
    write_reg(REG_INNER_KI, iki);
    write_reg(REG_BAND, band);
    write_reg(REG_TICKS, ticks);
    write_reg(REG_LIMIT, lim);
    write_reg(REG_D2A, d2a);
  endtask

  // Presents one control period and holds it until the transfer completes.
  task automatic send_period(period_t p);
    int g;
    g = no_idle ? 0 : gap_cycles();
    repeat (g) @(negedge clk);
    tilt_mdeg = p.tilt; left_delta_counts = p.dl; right_delta_counts = p.dr;
    left_total_counts = p.tl; right_total_counts = p.tr; elapsed_ms = p.ms;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
    sent++;
  endtask

  function automatic period_t rand_payload(int tilt);
    period_t p;
    int r;
    p.tilt = 19'(tilt);
    p.dl = 16'($urandom);
    p.dr = 16'($urandom);
    if ($urandom_range(1)) begin
      p.tl = $urandom;
      p.tr = $urandom;
    end else begin
      p.tl = $signed($urandom_range(40000)) - 20000;
      p.tr = $signed($urandom_range(40000)) - 20000;
    end
    r = $urandom_range(49);
    p.ms = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : 10'($urandom_range(1, 1000));
    return p;
  endfunction

  function automatic int signed_mag(int m);
    return $urandom_range(1) ? m : -m;
  endfunction

  // Random tilt whose magnitude lies in [lo, hi], clipped to the field.
  function automatic int tilt_between(longint lo, longint hi);
    if (hi > 262143) hi = 262143;
    if (lo > hi) lo = hi;
    return signed_mag(int'($urandom_range(int'(hi), int'(lo))));
  endfunction

  // Mostly well-formed arm/start/control sequences, the rest noise.
  task automatic random_periods(int n);
    int done_n, k, m;
    done_n = 0;
    while (done_n < n) begin
      if (sb.band > 0 && sb.ticks < 60 && $urandom_range(99) < 70) begin
        k = int'(sb.ticks) + 1 + $urandom_range(2);
        repeat (k) send_period(rand_payload(tilt_between(0, sb.band - 1)));
        m = $urandom_range(1, 12);
        repeat (m) begin
          if ($urandom_range(9) < 2)
            send_period(rand_payload(tilt_between(0, sb.band)));
          else
            send_period(rand_payload(tilt_between(sb.band + 1, sb.limit)));
        end
        if ($urandom_range(9) < 3)
          send_period(rand_payload(tilt_between(sb.limit + 1, 262143)));
        done_n += k + m + 1;
      end else begin
        repeat (4) send_period(rand_payload(signed_mag($urandom_range(262144) & 32'h3ffff)));
        done_n += 4;
      end
      no_idle = ($urandom_range(9) == 0);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    period_t p;
    int d;
    sb = new();
    sb.restore_defaults();
    cycles = 0;
    sent = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: band edges, field extremes, odd period lengths, then a short
    // arm, start, control and over-limit trip with a two-tick arm count.
    configure(-393216, -2359296, 39321600, 393216000, 3000, 2, 44690, 32768);
    send_period(rand_payload(3000));
    send_period(rand_payload(-3000));
    send_period(rand_payload(-262144));
    send_period(rand_payload(262143));
    for (d = 0; d < 3; d++) send_period(rand_payload(d * 1000 - 1000));
    send_period(rand_payload(3000));  // armed, edge tilt holds the phase
    p = rand_payload(3001);
    p.dl = 16'sh7fff; p.dr = 16'sh8000; p.tl = 32'sh7fffffff; p.tr = 32'sh7fffffff;
    p.ms = 10'd0;
    send_period(p);                   // control starts on this period
    p = rand_payload(-20000);
    p.dl = 16'sh8000; p.dr = 16'sh7fff; p.tl = 32'sh80000000; p.tr = 32'sh80000000;
    p.ms = 10'd1023;
    send_period(p);
    p.tilt = 19'sd100; p.ms = 10'd1000; p.tl = '0; p.tr = '0; p.dl = '0; p.dr = '0;
    send_period(p);
    p.tilt = 19'sd44690; send_period(p);   // exactly at the limit keeps control
    p.tilt = -19'sd44691; send_period(p);  // past the limit drops to waiting
    send_period(rand_payload(0));
    send_period(rand_payload(0));
    send_period(rand_payload(0));
    send_period(rand_payload(-50000));

    configure(-393216, -2359296, 39321600, 393216000, 3000, 30, 44690, 32768);
    random_periods(200);
    configure(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
              90000, 0, 180000, 65536);
    random_periods(160);
    configure(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
              1, 1, 0, 0);
    random_periods(120);
    configure(-393216, -2359296, 39321600, 393216000, 131071, 255, 262143, 131071);
    random_periods(40);
    configure(0, 0, 0, 0, 0, 4, 1000, 1);
    random_periods(30);
    repeat (5) begin
      configure($urandom, $urandom, $urandom, $urandom, $urandom_range(90000),
                $urandom_range(8), $urandom_range(180000), $urandom_range(65536));
      random_periods(120);
    end

    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("periods sent %0d, results checked %0d, controlled periods %0d, arm events %0d",
             sent, sb.results, sb.ctrl_periods, sb.arms);
    $display("register settings covered defaults, both gain extremes and random sets");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_cascaded_pi_balance_controller_unit: PASS");
    end else begin
      $display("tb_cascaded_pi_balance_controller_unit: FAIL");
    end
    $finish;
  end

endmodule
